@@ rtl/core/sim128_pkg.sv @@
// Package: types, constants and GF(2^8) functions for the Simpira-128 core.
`timescale 1ns / 1ps
`default_nettype none
package sim128_pkg;

  localparam int unsigned RoundPairs = 6;
  localparam int unsigned NumRounds = 2 * RoundPairs;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   valid;
    logic   inv;
    block_t data;
  } cell_bus_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    gf_mul = r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int unsigned n);
    rotl8 = 8'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] v;
    v = gf_inv(x);
    sbox_calc = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
    inv_sbox_calc = gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t build_sbox(input logic inv);
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    build_sbox = t;
  endfunction

  localparam sbox_arr_t SboxFwd = build_sbox(1'b0);
  localparam sbox_arr_t SboxInv = build_sbox(1'b1);

  function automatic block_t mix_cols(input block_t s, input logic inv);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    o = s;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      if (!inv) begin
        o[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end else begin
        o[32*c +: 8]    = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                        ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
        o[32*c+8 +: 8]  = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                        ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
        o[32*c+16 +: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                        ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
        o[32*c+24 +: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                        ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
      end
    end
    mix_cols = o;
  endfunction

  function automatic block_t round_key(input int unsigned idx, input logic inv);
    block_t k;
    k = '0;
    for (int j = 0; j < 4; j++) begin
      k[32*j +: 8] = 8'((32'h10 * j) ^ idx ^ 1);
    end
    round_key = inv ? mix_cols(k, 1'b1) : k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sim128_round_cell.sv @@
// One AES round cell of the permutation chain, forward or inverse per word.
`timescale 1ns / 1ps
`default_nettype none
module sim128_round_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  mix_i,
  input  wire sim128_pkg::block_t    key_fwd_i,
  input  wire sim128_pkg::block_t    key_inv_i,
  input  wire sim128_pkg::cell_bus_t bus_i,
  output sim128_pkg::cell_bus_t      bus_o
);

  sim128_pkg::block_t sub_d;
  sim128_pkg::block_t mixed_d;
  sim128_pkg::block_t data_d;
  sim128_pkg::block_t data_q;
  logic               valid_q;
  logic               inv_q;

  always_comb begin
    sub_d = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (bus_i.inv) begin
          sub_d[8*(r+4*c) +: 8] =
            sim128_pkg::SboxInv[bus_i.data[8*(r+4*((c-r+4)%4)) +: 8]];
        end else begin
          sub_d[8*(r+4*c) +: 8] =
            sim128_pkg::SboxFwd[bus_i.data[8*(r+4*((c+r)%4)) +: 8]];
        end
      end
    end
    mixed_d = mix_i ? sim128_pkg::mix_cols(sub_d, bus_i.inv) : sub_d;
    data_d  = mixed_d ^ (bus_i.inv ? key_inv_i : key_fwd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= bus_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_q  <= bus_i.inv;
      data_q <= data_d;
    end
  end

  assign bus_o = '{valid: valid_q, inv: inv_q, data: data_q};

endmodule
`default_nettype wire

@@ rtl/core/simpira_128_permutation_core.sv @@
// Top level of the Simpira-128 permutation core: chain of round cells.
`timescale 1ns / 1ps
`default_nettype none
// Twelve AES round cells stand in a chain, one round per cell, each registered,
// and one word enters every cycle unless the chain holds. tuser on the input
// selects the direction (0 forward, 1 inverse). When the output word waits,
// the whole chain holds and tready drops with it.
module simpira_128_permutation_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // data_lo[63:0], data_hi[127:64]
  input  wire logic         s_axis_tuser,  // cmd
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata   // result_lo[63:0], result_hi[127:64]
);

  localparam int unsigned N = sim128_pkg::NumRounds;

  sim128_pkg::cell_bus_t bus [N+1];
  logic                  en;

  assign en = m_axis_tready || !bus[N].valid;
  assign s_axis_tready = en;
  assign bus[0] = '{valid: s_axis_tvalid, inv: s_axis_tuser, data: s_axis_tdata};

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned Pair = g / 2;
    localparam bit Odd = (g % 2) == 0;
    localparam sim128_pkg::block_t KeyF =
      Odd ? sim128_pkg::round_key(Pair + 1, 1'b0) : '0;
    localparam sim128_pkg::block_t KeyI =
      Odd ? sim128_pkg::round_key(sim128_pkg::RoundPairs - Pair, 1'b1) : '0;
    sim128_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .mix_i     (g != N - 1),
      .key_fwd_i (KeyF),
      .key_inv_i (KeyI),
      .bus_i     (bus[g]),
      .bus_o     (bus[g+1])
    );
  end

  assign m_axis_tvalid = bus[N].valid;
  assign m_axis_tdata  = bus[N].data;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |=> bus[N].valid == $past(bus[N-1].valid))
    else $error("chain lost a word");

endmodule
`default_nettype wire
